FILE: hdl/stereo_bass_enhancer_macros.svh
// Concurrent check macros, empty for synthesis.
`ifndef STEREO_BASS_ENHANCER_MACROS_SVH
`define STEREO_BASS_ENHANCER_MACROS_SVH

`ifndef SYNTHESIS
`define STBE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stbe check failed");
`define STBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stbe check failed");
`else
`define STBE_ASSERT_IMP(label, ante, cons)
`define STBE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/stbe_pkg.sv
`default_nettype none

package stbe_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COEF_W      = 32;
    localparam int AMOUNT_W    = 17;
    localparam int GUARD_BITS  = 8;
    localparam int STATE_BITS  = 40;
    localparam int AMOUNT_FRAC = 16;
    localparam int BOOST_SHIFT = 2 + AMOUNT_FRAC + GUARD_BITS;

    localparam logic [AMOUNT_W-1:0] AMOUNT_ONE   = AMOUNT_W'(65536);
    localparam logic [AMOUNT_W-1:0] AMOUNT_RESET = AMOUNT_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_A1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_A2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_AMOUNT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_Y,
        ST_MUL_B1,
        ST_S1,
        ST_MUL_B2,
        ST_S2,
        ST_MUL_BOOST,
        ST_BOOST,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/stereo_bass_enhancer.sv
// Per item: ST_MUL_B0, ST_Y, ST_MUL_B1, ST_S1, ST_MUL_B2 and ST_S2 for each of the
// LOWPASS_STAGES+1 biquads, then ST_MUL_BOOST, ST_BOOST and ST_DONE; a multiply spans
// SIG = SAMPLE_BITS+10 bits. A zero boost amount goes straight to ST_DONE. One item at a
// time: a shared bit-serial multiply-accumulate unit takes one multiplier bit per cycle
// for every biquad product and the boost; the output register frees the input.
// Reset (synchronous, active low) clears coefficients, filter state and handshakes.
`default_nettype none
`include "stereo_bass_enhancer_macros.svh"

module stereo_bass_enhancer #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 30,
    parameter int LOWPASS_STAGES = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [stbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [stbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_right_in,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic signed [SAMPLE_BITS-1:0]       o_left_out,
    output      logic signed [SAMPLE_BITS-1:0]       o_right_out
);
    import stbe_pkg::*;

    localparam int SIG_BITS = SAMPLE_BITS + GUARD_BITS + 2;
    localparam int CW       = (SIG_BITS + 4 > COEF_W) ? SIG_BITS + 4 : COEF_W;
    localparam int ACC_W    = SIG_BITS + CW + 2;
    localparam int RND_W    = ACC_W - COEF_FRAC_BITS;
    localparam int SUM_W    = ((RND_W > STATE_BITS) ? RND_W : STATE_BITS) + 1;
    localparam int BOOST_W  = ACC_W - BOOST_SHIFT;
    localparam int OUT_W    = BOOST_W + 1;
    localparam int CNT_W    = $clog2(SIG_BITS);
    localparam int DEPTH    = LOWPASS_STAGES + 1;
    localparam int STG_W    = $clog2(DEPTH);

    localparam longint COEF_ONE = 64'sd1 <<< COEF_FRAC_BITS;
    localparam longint DC_B0_L  = (999 * COEF_ONE + 500) / 1000;
    localparam longint DC_B1_L  = -((1998 * COEF_ONE + 500) / 1000);
    localparam longint DC_A2_L  = (998 * COEF_ONE + 500) / 1000;

    localparam logic signed [CW-1:0] DC_B0 = CW'(DC_B0_L);
    localparam logic signed [CW-1:0] DC_B1 = CW'(DC_B1_L);
    localparam logic signed [CW-1:0] DC_A2 = CW'(DC_A2_L);

    localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] HALF_B = ACC_W'(64'sd1 <<< (BOOST_SHIFT - 1));

    localparam logic signed [SUM_W-1:0] SIG_MAX = SUM_W'((64'sd1 <<< (SIG_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SIG_MIN = SUM_W'(-(64'sd1 <<< (SIG_BITS - 1)));
    localparam logic signed [SUM_W-1:0] STA_MAX = SUM_W'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] STA_MIN = SUM_W'(-(64'sd1 <<< (STATE_BITS - 1)));
    localparam logic signed [OUT_W-1:0] SMP_MAX =
        OUT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [OUT_W-1:0] SMP_MIN = OUT_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SIG_BITS - 1);
    localparam logic [STG_W-1:0] STAGE_LAST = STG_W'(LOWPASS_STAGES);

    t_state r_state, n_state;

    logic signed [COEF_W-1:0]     r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [AMOUNT_W-1:0]          r_amount;
    logic signed [STATE_BITS-1:0] r_s1 [DEPTH];
    logic signed [STATE_BITS-1:0] r_s2 [DEPTH];
    logic signed [STATE_BITS-1:0] n_s1 [DEPTH];
    logic signed [STATE_BITS-1:0] n_s2 [DEPTH];
    logic [STG_W-1:0]             r_stage, n_stage;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;

    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic [SIG_BITS-1:0]           r_mx, n_mx, r_my, n_my;
    logic signed [SIG_BITS-1:0]    r_x, n_x, r_y, n_y;
    logic signed [CW-1:0]          r_t3, n_t3;
    logic signed [BOOST_W-1:0]     r_boost, n_boost;
    logic signed [SAMPLE_BITS-1:0] r_l, n_l, r_r, n_r;
    logic signed [SAMPLE_BITS-1:0] r_left_out, n_left_out, r_right_out, n_right_out;

    logic [AMOUNT_W-1:0]          amt_c;
    logic signed [SIG_BITS-1:0]   mono;
    logic                         lp;
    logic signed [CW-1:0]         c_b0, c_b1, c_b2, c_a1, c_a2, cx, cy;
    logic signed [ACC_W-1:0]      term, mac_next, acc_f, acc_b;
    logic signed [RND_W-1:0]      rnd_f;
    logic signed [SUM_W-1:0]      y_sum, s1_sum, s2_sum;
    logic signed [SIG_BITS-1:0]   y_sat;
    logic signed [STATE_BITS-1:0] s1_sat, s2_sat;
    logic signed [CW-1:0]         b_ext, b_mag, t3;
    logic signed [OUT_W-1:0]      sum_l, sum_r;
    logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
    logic                         mac_active;

    assign amt_c = (r_amount > AMOUNT_ONE) ? AMOUNT_ONE : r_amount;
    assign mono  = (SIG_BITS'(i_left_in) + SIG_BITS'(i_right_in)) <<< (GUARD_BITS - 1);

    assign lp   = (r_stage != STAGE_LAST);
    assign c_b0 = lp ? CW'(r_b0) : DC_B0;
    assign c_b1 = lp ? CW'(r_b1) : DC_B1;
    assign c_b2 = lp ? CW'(r_b2) : DC_B0;
    assign c_a1 = lp ? CW'(r_a1) : DC_B1;
    assign c_a2 = lp ? CW'(r_a2) : DC_A2;

    always_comb begin
        cx = '0;
        cy = '0;
        unique case (r_state)
            ST_MUL_B0: begin
                cx = c_b0;
            end
            ST_MUL_B1: begin
                cx = c_b1;
                cy = c_a1;
            end
            ST_MUL_B2: begin
                cx = c_b2;
                cy = c_a2;
            end
            ST_MUL_BOOST: begin
                cx = r_t3;
            end
            default: begin
                cx = '0;
            end
        endcase
    end

    assign mac_active = (r_state == ST_MUL_B0) || (r_state == ST_MUL_B1) ||
                        (r_state == ST_MUL_B2) || (r_state == ST_MUL_BOOST);

    assign term     = (r_mx[SIG_BITS-1] ? ACC_W'(cx) : ACC_W'(0))
                    - (r_my[SIG_BITS-1] ? ACC_W'(cy) : ACC_W'(0));
    assign mac_next = (r_cnt == CNT_LAST) ? -term : (r_acc <<< 1) + term;

    assign acc_f = r_acc + HALF_F;
    assign rnd_f = acc_f[ACC_W-1:COEF_FRAC_BITS];
    assign acc_b = r_acc + HALF_B;

    assign y_sum  = SUM_W'(rnd_f) + SUM_W'(r_s1[r_stage]);
    assign s1_sum = SUM_W'(rnd_f) + SUM_W'(r_s2[r_stage]);
    assign s2_sum = SUM_W'(rnd_f);

    assign y_sat  = (y_sum > SIG_MAX) ? SIG_MAX[SIG_BITS-1:0] :
                    (y_sum < SIG_MIN) ? SIG_MIN[SIG_BITS-1:0] : y_sum[SIG_BITS-1:0];
    assign s1_sat = (s1_sum > STA_MAX) ? STA_MAX[STATE_BITS-1:0] :
                    (s1_sum < STA_MIN) ? STA_MIN[STATE_BITS-1:0] : s1_sum[STATE_BITS-1:0];
    assign s2_sat = (s2_sum > STA_MAX) ? STA_MAX[STATE_BITS-1:0] :
                    (s2_sum < STA_MIN) ? STA_MIN[STATE_BITS-1:0] : s2_sum[STATE_BITS-1:0];

    assign b_ext = CW'(r_y);
    assign b_mag = r_y[SIG_BITS-1] ? -b_ext : b_ext;
    assign t3    = (b_ext <<< 3) + b_ext + (b_mag <<< 2) + (b_mag <<< 1);

    assign sum_l = OUT_W'(r_l) + OUT_W'(r_boost);
    assign sum_r = OUT_W'(r_r) + OUT_W'(r_boost);
    assign sat_l = (sum_l > SMP_MAX) ? SMP_MAX[SAMPLE_BITS-1:0] :
                   (sum_l < SMP_MIN) ? SMP_MIN[SAMPLE_BITS-1:0] : sum_l[SAMPLE_BITS-1:0];
    assign sat_r = (sum_r > SMP_MAX) ? SMP_MAX[SAMPLE_BITS-1:0] :
                   (sum_r < SMP_MIN) ? SMP_MIN[SAMPLE_BITS-1:0] : sum_r[SAMPLE_BITS-1:0];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_mx        = r_mx;
        n_my        = r_my;
        n_x         = r_x;
        n_y         = r_y;
        n_t3        = r_t3;
        n_boost     = r_boost;
        n_l         = r_l;
        n_r         = r_r;
        n_left_out  = r_left_out;
        n_right_out = r_right_out;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_out_valid = r_out_valid && !i_out_ready;

        if (mac_active) begin
            n_acc = mac_next;
            n_mx  = r_mx << 1;
            n_my  = r_my << 1;
            n_cnt = r_cnt - CNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_l     = i_left_in;
                    n_r     = i_right_in;
                    n_x     = mono;
                    n_mx    = mono;
                    n_my    = '0;
                    n_stage = '0;
                    n_cnt   = CNT_LAST;
                    if (amt_c == '0) begin
                        n_boost = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL_B0;
                    end
                end
            end
            ST_MUL_B0: begin
                if (r_cnt == '0) n_state = ST_Y;
            end
            ST_Y: begin
                n_y     = y_sat;
                n_mx    = r_x;
                n_my    = y_sat;
                n_cnt   = CNT_LAST;
                n_state = ST_MUL_B1;
            end
            ST_MUL_B1: begin
                if (r_cnt == '0) n_state = ST_S1;
            end
            ST_S1: begin
                n_s1[r_stage] = s1_sat;
                n_mx          = r_x;
                n_my          = r_y;
                n_cnt         = CNT_LAST;
                n_state       = ST_MUL_B2;
            end
            ST_MUL_B2: begin
                if (r_cnt == '0) n_state = ST_S2;
            end
            ST_S2: begin
                n_s2[r_stage] = s2_sat;
                n_cnt         = CNT_LAST;
                n_my          = '0;
                if (r_stage == STAGE_LAST) begin
                    n_t3    = t3;
                    n_mx    = SIG_BITS'(amt_c);
                    n_state = ST_MUL_BOOST;
                end else begin
                    n_stage = r_stage + STG_W'(1);
                    n_x     = r_y;
                    n_mx    = r_y;
                    n_state = ST_MUL_B0;
                end
            end
            ST_MUL_BOOST: begin
                if (r_cnt == '0) n_state = ST_BOOST;
            end
            ST_BOOST: begin
                n_boost = acc_b[ACC_W-1:BOOST_SHIFT];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_left_out  = sat_l;
                    n_right_out = sat_r;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_s1[i] <= '0;
                r_s2[i] <= '0;
            end
        end else begin
            r_stage     <= n_stage;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= '0;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_amount <= AMOUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWPASS_B0:   r_b0     <= i_cfg_data;
                CFG_LOWPASS_B1:   r_b1     <= i_cfg_data;
                CFG_LOWPASS_B2:   r_b2     <= i_cfg_data;
                CFG_LOWPASS_A1:   r_a1     <= i_cfg_data;
                CFG_LOWPASS_A2:   r_a2     <= i_cfg_data;
                CFG_BOOST_AMOUNT: r_amount <= i_cfg_data[AMOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_mx        <= n_mx;
        r_my        <= n_my;
        r_x         <= n_x;
        r_y         <= n_y;
        r_t3        <= n_t3;
        r_boost     <= n_boost;
        r_l         <= n_l;
        r_r         <= n_r;
        r_left_out  <= n_left_out;
        r_right_out <= n_right_out;
    end

    `STBE_ASSERT_NEXT(a_bypass, i_in_valid && o_in_ready && amt_c == '0, r_state == ST_DONE && r_boost == '0)
    `STBE_ASSERT_NEXT(a_y_step, r_state == ST_MUL_B0 && r_cnt == '0, r_state == ST_Y)
    `STBE_ASSERT_IMP(a_stage_range, r_state != ST_IDLE, r_stage <= STAGE_LAST)
    `STBE_ASSERT_NEXT(a_done, r_state == ST_DONE && (!r_out_valid || i_out_ready), o_out_valid && r_state == ST_IDLE)

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
    import stbe_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int LOWPASS_STAGES = 2;
    localparam int SIG_BITS       = SAMPLE_BITS + GUARD_BITS + 2;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 2500;
    localparam int TAIL_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_stereo;

    class bass_scoreboard;
        longint lp_coef[5];
        longint dc_coef_q[5];
        logic [AMOUNT_W-1:0] amount;
        longint delay_first[LOWPASS_STAGES+1];
        longint delay_second[LOWPASS_STAGES+1];
        t_stereo pending_pairs[$];
        int errors;
        int checked;
        int accepted;

        function new();
            foreach (lp_coef[i]) lp_coef[i] = 0;
            foreach (delay_first[i]) begin
                delay_first[i] = 0;
                delay_second[i] = 0;
            end
            amount = AMOUNT_RESET;
            dc_coef_q[0] = dc_coef(999);
            dc_coef_q[1] = dc_coef(-1998);
            dc_coef_q[2] = dc_coef(999);
            dc_coef_q[3] = dc_coef(-1998);
            dc_coef_q[4] = dc_coef(998);
            errors = 0;
            checked = 0;
            accepted = 0;
        endfunction

        function longint dc_coef(longint thousandths);
            longint mag;
            longint q;
            mag = thousandths < 0 ? -thousandths : thousandths;
            q = (mag * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000;
            return thousandths < 0 ? -q : q;
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint biquad(int stage, longint x, longint c[5]);
            longint y;
            y = clip(round_shift(c[0] * x, COEF_FRAC_BITS) + delay_first[stage], SIG_BITS);
            delay_first[stage] = clip(round_shift(c[1] * x - c[3] * y, COEF_FRAC_BITS)
                                      + delay_second[stage], STATE_BITS);
            delay_second[stage] = clip(round_shift(c[2] * x - c[4] * y, COEF_FRAC_BITS),
                                       STATE_BITS);
            return y;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOWPASS_B0:   lp_coef[0] = longint'($signed(data));
                CFG_LOWPASS_B1:   lp_coef[1] = longint'($signed(data));
                CFG_LOWPASS_B2:   lp_coef[2] = longint'($signed(data));
                CFG_LOWPASS_A1:   lp_coef[3] = longint'($signed(data));
                CFG_LOWPASS_A2:   lp_coef[4] = longint'($signed(data));
                CFG_BOOST_AMOUNT: amount = data[AMOUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_stereo boost_pair(logic signed [SAMPLE_BITS-1:0] l,
                                     logic signed [SAMPLE_BITS-1:0] r);
            t_stereo res;
            longint amt;
            longint bass;
            longint mag;
            longint boost;
            amt = amount > AMOUNT_ONE ? longint'(AMOUNT_ONE) : longint'(amount);
            res.left = l;
            res.right = r;
            if (amt == 0) return res;
            bass = (longint'(l) + longint'(r)) * (longint'(1) << (GUARD_BITS - 1));
            for (int i = 0; i < LOWPASS_STAGES; i++) bass = biquad(i, bass, lp_coef);
            bass = biquad(LOWPASS_STAGES, bass, dc_coef_q);
            mag = bass < 0 ? -bass : bass;
            boost = round_shift((3 * bass + 2 * mag) * 3 * amt, BOOST_SHIFT);
            res.left = SAMPLE_BITS'(clip(longint'(l) + boost, SAMPLE_BITS));
            res.right = SAMPLE_BITS'(clip(longint'(r) + boost, SAMPLE_BITS));
            return res;
        endfunction

        function void note_input(logic signed [SAMPLE_BITS-1:0] l,
                                 logic signed [SAMPLE_BITS-1:0] r);
            pending_pairs.push_back(boost_pair(l, r));
            accepted++;
        endfunction

        function void check_output(logic signed [SAMPLE_BITS-1:0] l,
                                   logic signed [SAMPLE_BITS-1:0] r);
            t_stereo exp_pair;
            checked++;
            if (pending_pairs.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected output item L=%0d R=%0d", l, r);
                return;
            end
            exp_pair = pending_pairs.pop_front();
            if (exp_pair.left !== l || exp_pair.right !== r) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("output item %0d wrong: expected L=%0d R=%0d, got L=%0d R=%0d",
                             checked, exp_pair.left, exp_pair.right, l, r);
            end
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_left_in   = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_in  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;

    bass_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycles = 0;
    int settings_used = 0;

    stereo_bass_enhancer #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .LOWPASS_STAGES(LOWPASS_STAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_left_out (o_left_out),
        .o_right_out(o_right_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold the output off for a long stretch on request, else stall at random
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_output(o_left_out, o_right_out);
    end

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(l, r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_lowpass(input logic [31:0] b0, input logic [31:0] b1,
                               input logic [31:0] b2, input logic [31:0] a1,
                               input logic [31:0] a2);
        write_reg(CFG_LOWPASS_B0, b0);
        write_reg(CFG_LOWPASS_B1, b1);
        write_reg(CFG_LOWPASS_B2, b2);
        write_reg(CFG_LOWPASS_A1, a1);
        write_reg(CFG_LOWPASS_A2, a2);
        settings_used++;
    endtask

    task automatic set_amount(input logic [31:0] amt);
        write_reg(CFG_BOOST_AMOUNT, amt);
        settings_used++;
    endtask

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 66; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            IDLE_BOTH:     begin send_idle_pct = 33; recv_stall_pct = 33; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic set_gentle_lowpass();
        set_lowpass(32'd180600, 32'd361200, 32'd180600, 32'(-2107738000), 32'd1034712000);
    endtask

    task automatic set_small_lowpass();
        set_lowpass(32'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000),
                    32'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000),
                    32'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000),
                    32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000),
                    32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000));
    endtask

    initial begin
        int wave_cnt;
        int wave_amp;
        bit wave_neg;
        int base;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;

        sb = new();
        wave_cnt = 0;
        wave_amp = 0;
        wave_neg = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients and amount
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        drain();

        // unity lowpass, full boost: rails, signs, step
        set_lowpass(32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        set_amount(32'(AMOUNT_ONE));
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd1, 16'sd1);
        send_pair(16'sd20000, 16'sd20000);
        send_pair(16'sd20000, 16'sd20000);
        drain();

        // bypass with state frozen
        set_amount(32'h0);
        send_pair(16'sd32767, -16'sd32768);
        send_pair(16'sd100, -16'sd100);
        drain();

        // amount above one, with all data bits set
        set_amount(32'hFFFF_FFFF);
        send_pair(16'sd20000, 16'sd20000);
        send_pair(-16'sd12345, 16'sd4321);
        drain();

        // writes to unmapped indexes change nothing
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0000);
        send_pair(16'sd5000, 16'sd7000);
        drain();

        // unstable coefficients drive the filters into saturation
        set_lowpass(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        set_amount(32'(AMOUNT_ONE));
        send_pair(16'sd32767, 16'sd32767);
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32768);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    set_gentle_lowpass();
                    set_amount(32'($urandom_range(1, 65536)));
                    set_idling(IDLE_NONE);
                    hold_req = HOLD_CYCLES;
                end
                1: begin
                    set_lowpass(32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
                    set_amount(32'(AMOUNT_ONE));
                    set_idling(IDLE_SENDER);
                end
                2: begin
                    set_lowpass($urandom, $urandom, $urandom, $urandom, $urandom);
                    set_amount($urandom);
                    set_idling(IDLE_RECEIVER);
                end
                3: begin
                    set_small_lowpass();
                    set_amount(32'h0);
                    set_idling(IDLE_BOTH);
                end
                4: begin
                    set_gentle_lowpass();
                    set_amount(32'h0001_FFFF);
                    set_idling(IDLE_BOTH);
                    hold_req = HOLD_CYCLES;
                end
                5: begin
                    set_small_lowpass();
                    set_amount(32'($urandom_range(1, 131071)));
                    set_idling(IDLE_NONE);
                end
                6: begin
                    set_lowpass(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000);
                    set_amount(32'h1);
                    set_idling(IDLE_SENDER);
                end
                default: begin
                    set_lowpass($urandom, 32'h0, $urandom, 32'h0, 32'h0);
                    set_amount(32'(AMOUNT_RESET));
                    set_idling(IDLE_RECEIVER);
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 70) begin
                    if (wave_cnt == 0) begin
                        wave_cnt = $urandom_range(2, 40);
                        wave_amp = $urandom_range(0, 32767);
                        wave_neg = ~wave_neg;
                    end
                    wave_cnt--;
                    base = wave_neg ? -wave_amp : wave_amp;
                    l = clamp_sample(base + int'($urandom_range(0, 512)) - 256);
                    r = clamp_sample(base + int'($urandom_range(0, 512)) - 256);
                end else begin
                    l = SAMPLE_BITS'($urandom);
                    r = SAMPLE_BITS'($urandom);
                end
                send_pair(l, r);
            end
            drain();
        end

        set_idling(IDLE_NONE);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d stereo items over %0d register settings: bypass, clipped amount,",
                 sb.accepted, settings_used);
        $display("saturating filters, random idling and a long output hold-off; %0d results, %0d bad",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/stbe_pkg.sv
hdl/stereo_bass_enhancer.sv
test/tb.sv
